// File: rtl/rgbpal_pkg.sv
`default_nettype none
package rgbpal_pkg;
	localparam int PAL_DEPTH = 256;
	localparam int PAL_AW = 8;
	localparam int SET_DEPTH = 32;
	localparam int SET_AW = 5;
	localparam int SET_CW = 6;
	localparam int QDEPTH = 2;
	localparam logic [23:0] CNT_MAX = 24'hFFFFFF;

	typedef enum logic [1:0] {
		FN_PAL_WRITE = 2'd0,
		FN_PIXEL = 2'd1,
		FN_FRAME_START = 2'd2,
		FN_REPORT = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KD_ACK = 2'd0,
		KD_PIXEL = 2'd1,
		KD_COUNT = 2'd2,
		KD_COLOR = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		RG_COLOR_BITS = 2'd0,
		RG_DEFAULT_INDEX = 2'd1,
		RG_COLLECT_ALL = 2'd2
	} reg_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_SCAN = 2'd1,
		ST_REPORT = 2'd2
	} state_t;

	// classified item passed from front to back
	typedef struct packed {
		func_t func;
		logic [7:0] entry_index;
		logic [23:0] color;
		logic found;
		logic [7:0] idx;
		logic bad;
	} cmd_t;

	function automatic logic [23:0] vga_color(input logic [3:0] i);
		logic [23:0] c;
		case (i)
			4'd0: c = 24'h000000;
			4'd1: c = 24'hFFFFFF;
			4'd2: c = 24'hFF0000;
			4'd3: c = 24'hFFFF00;
			4'd4: c = 24'h00FF00;
			4'd5: c = 24'h00FFFF;
			4'd6: c = 24'h0000FF;
			4'd7: c = 24'hFF00FF;
			4'd8: c = 24'h808080;
			4'd9: c = 24'hC0C0C0;
			4'd10: c = 24'h800000;
			4'd11: c = 24'h808000;
			4'd12: c = 24'h008000;
			4'd13: c = 24'h008080;
			4'd14: c = 24'h000080;
			4'd15: c = 24'h800080;
			default: c = 24'h000000;
		endcase
		return c;
	endfunction

	// number of palette entries in use, minus one
	function automatic logic [7:0] last_entry(input logic [3:0] cb);
		logic [3:0] b;
		b = cb;
		if (b < 4'd1) b = 4'd1;
		if (b > 4'd8) b = 4'd8;
		return 8'((9'd1 << b) - 9'd1);
	endfunction
endpackage
`default_nettype wire

// File: rtl/rgbpal_front.sv
`default_nettype none
module rgbpal_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [1:0] func,
	input  wire logic [7:0] entry_index,
	input  wire logic [23:0] color,
	input  wire logic [3:0] color_bits,
	output logic cmd_valid,
	input  wire logic cmd_ready,
	output rgbpal_pkg::cmd_t cmd
);
	// palette in flops with valid bits; one entry read and compared per cycle
	logic [23:0] pal_q [rgbpal_pkg::PAL_DEPTH];
	logic [rgbpal_pkg::PAL_DEPTH-1:0] wr_q;
	rgbpal_pkg::state_t state_q, state_d;
	logic [7:0] ptr_q;
	logic [1:0] func_q;
	logic [7:0] ent_q;
	logic [23:0] col_q;
	logic [23:0] pal_rd_q;
	logic wr_rd_q;
	logic [rgbpal_pkg::PAL_AW-1:0] rd_addr;
	logic [7:0] lastn;
	logic [23:0] cur;
	logic hit;

	assign lastn = rgbpal_pkg::last_entry(color_bits);
	// read address runs one entry ahead so that the data is registered
	assign rd_addr = (in_valid && in_ready) ? '0 :
		((state_q == rgbpal_pkg::ST_SCAN && !cmd_valid) ? ptr_q + 8'd1 : ptr_q);
	assign cur = wr_rd_q ? pal_rd_q :
		((ptr_q < 8'd16) ? rgbpal_pkg::vga_color(ptr_q[3:0]) : 24'h0);
	assign hit = (cur == col_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			rgbpal_pkg::ST_IDLE: if (in_valid) state_d = rgbpal_pkg::ST_SCAN;
			rgbpal_pkg::ST_SCAN: begin
				if (rgbpal_pkg::func_t'(func_q) != rgbpal_pkg::FN_PIXEL || hit ||
						ptr_q == lastn) begin
					if (cmd_ready) state_d = rgbpal_pkg::ST_IDLE;
				end
			end
			default: state_d = rgbpal_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == rgbpal_pkg::ST_IDLE);
		cmd_valid = (state_q == rgbpal_pkg::ST_SCAN) &&
			(rgbpal_pkg::func_t'(func_q) != rgbpal_pkg::FN_PIXEL || hit || ptr_q == lastn);
		cmd.func = rgbpal_pkg::func_t'(func_q);
		cmd.entry_index = ent_q;
		cmd.color = col_q;
		cmd.found = hit;
		cmd.idx = ptr_q;
		cmd.bad = (ent_q > lastn);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rgbpal_pkg::ST_IDLE;
			wr_q <= '0;
			ptr_q <= '0;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) ptr_q <= '0;
			else if (state_q == rgbpal_pkg::ST_SCAN && !cmd_valid) ptr_q <= ptr_q + 8'd1;
			if (cmd_valid && cmd_ready && cmd.func == rgbpal_pkg::FN_PAL_WRITE && !cmd.bad)
				wr_q[ent_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_q <= func;
			ent_q <= entry_index;
			col_q <= color;
		end
		pal_rd_q <= pal_q[rd_addr];
		wr_rd_q <= wr_q[rd_addr];
		if (cmd_valid && cmd_ready && cmd.func == rgbpal_pkg::FN_PAL_WRITE && !cmd.bad)
			pal_q[ent_q] <= col_q;
	end

	a_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rgbpal_pkg::ST_SCAN |-> ptr_q <= lastn)
		else $error("scan pointer past entries in use");
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> !in_ready)
		else $error("front accepts while busy");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> state_q == rgbpal_pkg::ST_IDLE)
		else $error("front not idle after hand-off");
endmodule
`default_nettype wire

// File: rtl/rgbpal_back.sv
`default_nettype none
module rgbpal_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic cmd_ready,
	input  wire rgbpal_pkg::cmd_t cmd,
	input  wire logic [7:0] default_index,
	input  wire logic collect_all,
	input  wire logic [3:0] color_bits,
	output logic out_valid,
	input  wire logic out_ready,
	output logic [1:0] kind,
	output logic status,
	output logic [7:0] pal_index,
	output logic undefined,
	output logic [23:0] count,
	output logic [5:0] set_size,
	output logic overflow,
	output logic [23:0] color,
	output logic last
);
	logic [23:0] set_q [rgbpal_pkg::SET_DEPTH];
	logic [rgbpal_pkg::SET_CW-1:0] cnt_q, ptr_q;
	logic [23:0] undef_q;
	logic ovf_q;
	rgbpal_pkg::state_t state_q, state_d;
	rgbpal_pkg::cmd_t c_q;
	logic ins_q, dup_q;
	logic [7:0] lastn;
	logic [23:0] rd;
	logic sfree;
	logic [23:0] ncnt;
	logic [rgbpal_pkg::SET_CW-1:0] nsize;
	logic novf;

	assign lastn = rgbpal_pkg::last_entry(color_bits);
	assign rd = set_q[ptr_q[rgbpal_pkg::SET_AW-1:0]];
	assign sfree = !out_valid || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			rgbpal_pkg::ST_IDLE:
				if (cmd_valid && cmd_ready) state_d = (cmd.func == rgbpal_pkg::FN_PIXEL ||
					cmd.func == rgbpal_pkg::FN_REPORT) ? rgbpal_pkg::ST_SCAN : rgbpal_pkg::ST_IDLE;
			rgbpal_pkg::ST_SCAN: begin
				if (c_q.func == rgbpal_pkg::FN_REPORT) begin
					if (sfree) state_d = (cnt_q == '0) ? rgbpal_pkg::ST_IDLE : rgbpal_pkg::ST_REPORT;
				end else if (!ins_q || dup_q || ptr_q == cnt_q) begin
					if (sfree) state_d = rgbpal_pkg::ST_IDLE;
				end
			end
			rgbpal_pkg::ST_REPORT:
				if (sfree && ptr_q + 1'b1 == cnt_q) state_d = rgbpal_pkg::ST_IDLE;
			default: state_d = rgbpal_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = (state_q == rgbpal_pkg::ST_IDLE) && sfree;
		ncnt = undef_q;
		nsize = cnt_q;
		novf = ovf_q;
		if (!c_q.found && undef_q != rgbpal_pkg::CNT_MAX) ncnt = undef_q + 24'd1;
		if (ins_q && !dup_q) begin
			if (cnt_q < rgbpal_pkg::SET_CW'(rgbpal_pkg::SET_DEPTH)) nsize = cnt_q + 1'b1;
			else novf = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rgbpal_pkg::ST_IDLE;
			cnt_q <= '0;
			undef_q <= '0;
			ovf_q <= 1'b0;
			out_valid <= 1'b0;
			ptr_q <= '0;
			ins_q <= 1'b0;
			dup_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				rgbpal_pkg::ST_IDLE: begin
					ptr_q <= '0;
					dup_q <= 1'b0;
					ins_q <= !cmd.found || collect_all;
					if (cmd_valid && cmd_ready) begin
						if (cmd.func == rgbpal_pkg::FN_FRAME_START) begin
							cnt_q <= '0;
							undef_q <= '0;
							ovf_q <= 1'b0;
						end
						if (cmd.func == rgbpal_pkg::FN_PAL_WRITE ||
								cmd.func == rgbpal_pkg::FN_FRAME_START)
							out_valid <= 1'b1;
					end
				end
				rgbpal_pkg::ST_SCAN: begin
					if (c_q.func == rgbpal_pkg::FN_REPORT) begin
						if (sfree) out_valid <= 1'b1;
					end else if (!ins_q || dup_q || ptr_q == cnt_q) begin
						if (sfree) begin
							out_valid <= 1'b1;
							undef_q <= ncnt;
							cnt_q <= nsize;
							ovf_q <= novf;
						end
					end else if (rd == c_q.color) dup_q <= 1'b1;
					else ptr_q <= ptr_q + 1'b1;
				end
				rgbpal_pkg::ST_REPORT: begin
					if (sfree) begin
						out_valid <= 1'b1;
						ptr_q <= ptr_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) c_q <= cmd;
		if (state_q == rgbpal_pkg::ST_SCAN && c_q.func == rgbpal_pkg::FN_PIXEL && ins_q &&
				!dup_q && ptr_q == cnt_q && sfree &&
				cnt_q < rgbpal_pkg::SET_CW'(rgbpal_pkg::SET_DEPTH))
			set_q[cnt_q[rgbpal_pkg::SET_AW-1:0]] <= c_q.color;
		if (sfree) begin
			kind <= rgbpal_pkg::KD_ACK;
			status <= 1'b0;
			pal_index <= '0;
			undefined <= 1'b0;
			count <= '0;
			set_size <= '0;
			overflow <= 1'b0;
			color <= '0;
			last <= 1'b1;
			case (state_q)
				rgbpal_pkg::ST_IDLE: if (cmd.func == rgbpal_pkg::FN_PAL_WRITE) begin
					status <= cmd.bad;
					pal_index <= cmd.entry_index;
					color <= cmd.color;
				end
				rgbpal_pkg::ST_SCAN: if (c_q.func == rgbpal_pkg::FN_REPORT) begin
					kind <= rgbpal_pkg::KD_COUNT;
					count <= undef_q;
					set_size <= cnt_q;
					overflow <= ovf_q;
					last <= (cnt_q == '0);
				end else begin
					kind <= rgbpal_pkg::KD_PIXEL;
					pal_index <= c_q.found ? c_q.idx : default_index;
					status <= !c_q.found && (default_index > lastn);
					undefined <= !c_q.found;
					count <= ncnt;
					set_size <= nsize;
					overflow <= novf;
					color <= c_q.color;
				end
				rgbpal_pkg::ST_REPORT: begin
					kind <= rgbpal_pkg::KD_COLOR;
					color <= rd;
					last <= (ptr_q + 1'b1 == cnt_q);
				end
				default: ;
			endcase
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= rgbpal_pkg::SET_CW'(rgbpal_pkg::SET_DEPTH))
		else $error("set count beyond depth");
	a_rep: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rgbpal_pkg::ST_REPORT |-> ptr_q < cnt_q)
		else $error("report past set end");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(cnt_q) && $stable(undef_q))
		else $error("state moved under stalled result");
endmodule
`default_nettype wire

// File: rtl/rgbpal_queue.sv
`default_nettype none
module rgbpal_queue (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire rgbpal_pkg::cmd_t in_cmd,
	output logic out_valid,
	input  wire logic out_ready,
	output rgbpal_pkg::cmd_t out_cmd
);
	rgbpal_pkg::cmd_t mem_q [rgbpal_pkg::QDEPTH];
	logic wp_q, rp_q;
	logic [1:0] n_q;
	assign in_ready = (n_q != 2'd2);
	assign out_valid = (n_q != 2'd0);
	assign out_cmd = mem_q[rp_q];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			n_q <= '0;
		end else begin
			if (in_valid && in_ready) wp_q <= !wp_q;
			if (out_valid && out_ready) rp_q <= !rp_q;
			n_q <= n_q + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
		end
	end
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) mem_q[wp_q] <= in_cmd;
	end
endmodule
`default_nettype wire

// File: rtl/rgb_to_palette_index_mapper.sv
`default_nettype none
// pixel scans the palette in the front, then the set in the back when the colour is to be collected
// palette write and frame start give an acknowledgement; report gives 1 + set size results
// front and back each take one transaction at a time, with a two-entry queue between them
// arst_n clears control state, palette returns to the vga colours in entries 0 to 15 and zero above, set empties
// registers reset to color_bits 8, default_index 0, collect_all 0
module rgb_to_palette_index_mapper (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [3:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [1:0] func,
	input  wire logic [7:0] entry_index,
	input  wire logic [7:0] red,
	input  wire logic [7:0] green,
	input  wire logic [7:0] blue,
	output logic out_valid,
	input  wire logic out_ready,
	output logic [1:0] kind,
	output logic status,
	output logic [7:0] pal_index,
	output logic undefined,
	output logic [23:0] count,
	output logic [5:0] set_size,
	output logic overflow,
	output logic [23:0] color,
	output logic last
);
	logic [3:0] cb_q;
	logic [7:0] di_q;
	logic ca_q;
	logic f_v, f_r, b_v, b_r;
	rgbpal_pkg::cmd_t f_cmd, b_cmd;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cb_q <= 4'd8;
			di_q <= '0;
			ca_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (rgbpal_pkg::reg_t'(paddr[3:2]))
				rgbpal_pkg::RG_COLOR_BITS: cb_q <= pwdata[3:0];
				rgbpal_pkg::RG_DEFAULT_INDEX: di_q <= pwdata[7:0];
				rgbpal_pkg::RG_COLLECT_ALL: ca_q <= pwdata[0];
				default: ;
			endcase
		end
	end
	always_comb begin
		case (rgbpal_pkg::reg_t'(paddr[3:2]))
			rgbpal_pkg::RG_COLOR_BITS: prdata = {28'd0, cb_q};
			rgbpal_pkg::RG_DEFAULT_INDEX: prdata = {24'd0, di_q};
			rgbpal_pkg::RG_COLLECT_ALL: prdata = {31'd0, ca_q};
			default: prdata = '0;
		endcase
	end

	rgbpal_front u_front (.clk, .arst_n, .in_valid, .in_ready, .func, .entry_index,
		.color({red, green, blue}), .color_bits(cb_q), .cmd_valid(f_v), .cmd_ready(f_r),
		.cmd(f_cmd));
	rgbpal_queue u_queue (.clk, .arst_n, .in_valid(f_v), .in_ready(f_r), .in_cmd(f_cmd),
		.out_valid(b_v), .out_ready(b_r), .out_cmd(b_cmd));
	rgbpal_back u_back (.clk, .arst_n, .cmd_valid(b_v), .cmd_ready(b_r), .cmd(b_cmd),
		.default_index(di_q), .collect_all(ca_q), .color_bits(cb_q), .out_valid,
		.out_ready, .kind, .status, .pal_index, .undefined, .count, .set_size,
		.overflow, .color, .last);
endmodule
`default_nettype wire
